// ----- hw/rtl/mae_pkg.sv -----
// Shared types and constants for the moving average block.
// No dependencies; imported by every module of the block.
package mae_pkg;

	localparam int PRICE_W     = 32;
	localparam int WL_W        = 7;
	localparam int WEIGHT_W    = 17;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 17;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = 17'h10000;
	localparam logic [WEIGHT_W-1:0] WEIGHT_HALF = 17'h08000;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_WINDOW_LENGTH = 2'd0,
		REG_EMA_WEIGHT    = 2'd1
	} cfg_reg_t;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_SETUP  = 7'b0000010,
		ST_FETCH  = 7'b0000100,
		ST_MUL    = 7'b0001000,
		ST_ACC    = 7'b0010000,
		ST_DSTART = 7'b0100000,
		ST_DIV    = 7'b1000000
	} seq_state_t;

endpackage

// ----- hw/rtl/mae_ring.sv -----
// Price ring store: one write port and one registered read port.
// Depends on mae_pkg for the price width.
module mae_ring
	import mae_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic               clk,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  logic [PRICE_W-1:0] wr_data,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	output logic [PRICE_W-1:0] rd_data
);

	logic [PRICE_W-1:0] mem_q [DEPTH];
	logic [PRICE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hw/rtl/mae_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
// Depends on mae_pkg for the quotient width.
module mae_div
	import mae_pkg::*;
#(
	parameter int DIVIDEND_W = 38,
	parameter int DIVISOR_W  = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [PRICE_W-1:0]    quotient
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dsr_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  qbit;
	logic [DIVISOR_W-1:0]  rem_next;

	always_comb begin
		trial = {rem_q, quo_q[DIVIDEND_W-1]};
		diff  = trial - {1'b0, dsr_q};
		qbit  = (trial >= {1'b0, dsr_q});
		// The partial remainder always stays below the divisor.
		rem_next = qbit ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DIVIDEND_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], qbit};
			rem_q <= rem_next;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q[PRICE_W-1:0];

endmodule

// ----- hw/rtl/moving_average_and_ema_top.sv -----
// Channel  | handshake              | payload
// in       | in_valid / in_ready    | close_price
// out      | out_valid / out_ready  | simple_average, exp_average
// cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// After a price is accepted the block takes no other until its result is in the output
// register. The window in use is walked through the one shared multiplier, with a multiply
// step for each stored price and an accumulate step for each price after the oldest; then
// the serial divider works out one quotient bit per sum bit (SUM_W = 38 at the default depth).
// The ring store has no reset; only entries already written are ever read.
// A finished word waits in the output register while out_ready is low; the next price
// is accepted meanwhile, but its result is held in the divider until that register is free.
// Depends on mae_pkg, mae_ring and mae_div.
module moving_average_and_ema_top
	import mae_pkg::*;
#(
	parameter int WINDOW_MAX = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [PRICE_W-1:0]     close_price,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [PRICE_W-1:0]     simple_average,
	output logic [PRICE_W-1:0]     exp_average,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int AW     = $clog2(WINDOW_MAX);
	localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
	localparam int SPAN_W = (CNT_W > WL_W) ? CNT_W : WL_W;
	localparam int SUM_W  = PRICE_W + $clog2(WINDOW_MAX);
	localparam int PROD_W = WEIGHT_W + 1 + PRICE_W + 1;

	seq_state_t state_q;

	logic [WL_W-1:0]        window_length_q;
	logic [WEIGHT_W-1:0]    ema_weight_q;
	logic [AW-1:0]          write_slot_q;
	logic [CNT_W-1:0]       seen_q;
	logic [CNT_W-1:0]       left_q;
	logic                   first_q;
	logic [AW-1:0]          rd_addr_q;
	logic [SUM_W-1:0]       sum_q;
	logic [PRICE_W-1:0]     ema_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                   out_valid_q;
	logic [PRICE_W-1:0]     simple_q;
	logic [PRICE_W-1:0]     exp_q;

	logic                   in_fire;
	logic                   out_free;
	logic [PRICE_W-1:0]     rd_data;
	logic                   rd_en;
	logic                   div_start;
	logic                   div_done;
	logic [PRICE_W-1:0]     div_quo;
	logic [SPAN_W-1:0]      span_ext;
	logic [CNT_W-1:0]       span;
	logic [CNT_W:0]         slot_ext;
	logic [CNT_W:0]         start_calc;
	logic [WEIGHT_W-1:0]    w_eff;
	logic signed [PRICE_W:0] diff;
	logic signed [PROD_W-1:0] acc_sum;

	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] a);
		next_slot = (a == AW'(WINDOW_MAX - 1)) ? '0 : a + 1'b1;
	endfunction

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;
	assign rd_en     = (state_q == ST_FETCH) || (state_q == ST_MUL);
	assign div_start = (state_q == ST_DSTART);

	// Window in use: at least one, at most the ring depth and the prices seen.
	always_comb begin
		span_ext = SPAN_W'(window_length_q);
		if (span_ext == '0) begin
			span_ext = SPAN_W'(1);
		end
		if (span_ext > SPAN_W'(WINDOW_MAX)) begin
			span_ext = SPAN_W'(WINDOW_MAX);
		end
		if (span_ext > SPAN_W'(seen_q)) begin
			span_ext = SPAN_W'(seen_q);
		end
		span = span_ext[CNT_W-1:0];
		slot_ext = (CNT_W + 1)'(write_slot_q);
		if (slot_ext >= {1'b0, span}) begin
			start_calc = slot_ext - {1'b0, span};
		end else begin
			start_calc = slot_ext + (CNT_W + 1)'(WINDOW_MAX) - {1'b0, span};
		end
	end

	// ema + w * (p - ema) carries the same value as w * p + (1 - w) * ema.
	always_comb begin
		w_eff   = (ema_weight_q > WEIGHT_ONE) ? WEIGHT_ONE : ema_weight_q;
		diff    = $signed({1'b0, rd_data}) - $signed({1'b0, ema_q});
		acc_sum = $signed({3'b000, ema_q, 16'h0000}) + prod_q
			+ $signed(PROD_W'(WEIGHT_HALF));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= WL_W'(1);
			ema_weight_q    <= WEIGHT_ONE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WINDOW_LENGTH: window_length_q <= cfg_data[WL_W-1:0];
				REG_EMA_WEIGHT:    ema_weight_q    <= cfg_data[WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			write_slot_q <= '0;
			seen_q       <= '0;
			left_q       <= '0;
			first_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !(state_q == ST_DIV && div_done)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						write_slot_q <= next_slot(write_slot_q);
						if (seen_q < CNT_W'(WINDOW_MAX)) begin
							seen_q <= seen_q + 1'b1;
						end
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					left_q  <= span;
					first_q <= 1'b1;
					state_q <= ST_FETCH;
				end
				ST_FETCH: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					left_q  <= left_q - 1'b1;
					first_q <= 1'b0;
					if (!first_q) begin
						state_q <= ST_ACC;
					end else if (left_q == CNT_W'(1)) begin
						state_q <= ST_DSTART;
					end
				end
				ST_ACC: begin
					state_q <= (left_q == '0) ? ST_DSTART : ST_MUL;
				end
				ST_DSTART: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done && out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SETUP) begin
			rd_addr_q <= start_calc[AW-1:0];
			sum_q     <= '0;
		end else if (rd_en) begin
			rd_addr_q <= next_slot(rd_addr_q);
		end
		if (state_q == ST_MUL) begin
			sum_q <= sum_q + SUM_W'(rd_data);
			if (first_q) begin
				ema_q <= rd_data;
			end else begin
				prod_q <= $signed({1'b0, w_eff}) * diff;
			end
		end
		if (state_q == ST_ACC) begin
			ema_q <= acc_sum[PRICE_W+15:16];
		end
		if (state_q == ST_DIV && div_done && out_free) begin
			simple_q <= div_quo;
			exp_q    <= ema_q;
		end
	end

	mae_ring #(
		.DEPTH (WINDOW_MAX),
		.AW    (AW)
	) u_ring (
		.clk     (clk),
		.wr_en   (in_fire),
		.wr_addr (write_slot_q),
		.wr_data (close_price),
		.rd_en   (rd_en),
		.rd_addr (rd_addr_q),
		.rd_data (rd_data)
	);

	mae_div #(
		.DIVIDEND_W (SUM_W),
		.DIVISOR_W  (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (left_q == '0 ? span : span),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign out_valid      = out_valid_q;
	assign simple_average = simple_q;
	assign exp_average    = exp_q;

	// The window walk starts with at least one price, and never more than were stored.
	a_span_ok: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FETCH |-> left_q != '0 && left_q <= seen_q)
		else $error("window span out of range at start of walk");

	// The multiply step always has a price left to consume.
	a_mul_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |-> left_q != '0)
		else $error("multiply step with no price left");

	// An accepted word always starts a fresh setup.
	a_accept_setup: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == ST_SETUP)
		else $error("accepted word did not start the sequencer");

	// A result appears only when the divider has finished.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DIV && div_done))
		else $error("result raised without a finished division");

	// The count of stored prices saturates at the ring depth.
	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= CNT_W'(WINDOW_MAX))
		else $error("stored price count beyond ring depth");

endmodule

// ----- tb/sv/average_monitor.sv -----
// Watches the price, result and register channels of the moving average block.
// It predicts both averages for every accepted price and compares them in order.
// Depends on mae_pkg; the testbench top instantiates it beside the block.
module average_monitor
	import mae_pkg::*;
#(
	parameter int WINDOW_MAX = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic [PRICE_W-1:0]     close_price,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic [PRICE_W-1:0]     simple_average,
	input  logic [PRICE_W-1:0]     exp_average,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   run_done,
	output int unsigned            results_seen,
	output int unsigned            error_count
);

	localparam int SLOT_W = $clog2(WINDOW_MAX);
	localparam int SEEN_W = $clog2(WINDOW_MAX) + 1;

	typedef struct packed {
		logic [PRICE_W-1:0] simple;
		logic [PRICE_W-1:0] expo;
	} averages_t;

	logic [PRICE_W-1:0]  price_hist [WINDOW_MAX];
	logic [SLOT_W-1:0]   next_slot;
	logic [SEEN_W-1:0]   stored;
	logic [WL_W-1:0]     span_reg;
	logic [WEIGHT_W-1:0] weight_reg;
	averages_t           expected_averages [$];
	logic                closing_done;

	task automatic report_mismatch(input string msg);
		$display("%0t: mismatch: %s", $time, msg);
		error_count++;
	endtask

	// Stores the price, then averages over the newest prices that the window covers.
	function automatic averages_t average_window(input logic [PRICE_W-1:0] price);
		int unsigned span;
		int unsigned first;
		logic [63:0] total;
		logic [63:0] smooth;
		logic [63:0] wt;
		logic [63:0] p;
		averages_t   r;
		price_hist[next_slot] = price;
		next_slot = SLOT_W'((int'(next_slot) + 1) % WINDOW_MAX);
		if (stored < WINDOW_MAX)
			stored++;
		span = (span_reg == 0) ? 1 : span_reg;
		if (span > WINDOW_MAX)
			span = WINDOW_MAX;
		if (span > stored)
			span = stored;
		wt = (weight_reg > WEIGHT_ONE) ? 64'(WEIGHT_ONE) : 64'(weight_reg);
		first = (int'(next_slot) + WINDOW_MAX - span) % WINDOW_MAX;
		total = '0;
		smooth = '0;
		for (int unsigned k = 0; k < span; k++) begin
			p = 64'(price_hist[(first + k) % WINDOW_MAX]);
			total += p;
			// The oldest price in the window seeds the exponential average.
			if (k == 0)
				smooth = p;
			else
				smooth = (wt * p + (64'(WEIGHT_ONE) - wt) * smooth + 64'(WEIGHT_HALF)) >> 16;
		end
		r.simple = PRICE_W'(total / span);
		r.expo = smooth[PRICE_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		averages_t want;
		if (!arst_n) begin
			next_slot = '0;
			stored = '0;
			span_reg = WL_W'(1);
			weight_reg = WEIGHT_ONE;
			expected_averages.delete();
			results_seen = 0;
			error_count = 0;
			closing_done = 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_WINDOW_LENGTH)
					span_reg = cfg_data[WL_W-1:0];
				else if (cfg_index == REG_EMA_WEIGHT)
					weight_reg = cfg_data[WEIGHT_W-1:0];
			end
			if (in_valid && in_ready)
				expected_averages.insert(expected_averages.size(),
					average_window(close_price));
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_averages.size() == 0) begin
					report_mismatch($sformatf("result word %h %h with no price pending",
						simple_average, exp_average));
				end else begin
					want = expected_averages.pop_front();
					if (simple_average !== want.simple)
						report_mismatch($sformatf("simple_average got %h, want %h",
							simple_average, want.simple));
					if (exp_average !== want.expo)
						report_mismatch($sformatf("exp_average got %h, want %h",
							exp_average, want.expo));
				end
			end
			if (run_done && !closing_done) begin
				closing_done = 1'b1;
				if (expected_averages.size() != 0)
					report_mismatch($sformatf("%0d result words never arrived",
						expected_averages.size()));
			end
		end
	end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the moving average testbench: clock, reset, price and register stimulus.
// Depends on mae_pkg, moving_average_and_ema_top and average_monitor, which does the checking.
module testbench;
	import mae_pkg::*;

	localparam int WINDOW_MAX      = 64;
	localparam int SETTLE_CYCLES   = 2 * WINDOW_MAX + PRICE_W + $clog2(WINDOW_MAX) + 8;
	localparam int QUIET_LIMIT     = 20000;
	localparam int PHASES          = 12;
	localparam int ITEMS_PER_PHASE = 75;

	// Indexes past the register list, which the block must ignore.
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [PRICE_W-1:0]     close_price = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [PRICE_W-1:0]     simple_average;
	logic [PRICE_W-1:0]     exp_average;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   run_done = 1'b0;
	int unsigned            results_seen;
	int unsigned            error_count;
	int unsigned            items_sent = 0;
	int unsigned            sender_idle_pct = 0;
	int unsigned            receiver_stall_pct = 0;
	int unsigned            quiet_cycles = 0;
	logic [PRICE_W-1:0]     price_level = 32'h0064_0000;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	moving_average_and_ema_top #(
		.WINDOW_MAX(WINDOW_MAX)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.close_price   (close_price),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.simple_average(simple_average),
		.exp_average   (exp_average),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	average_monitor #(
		.WINDOW_MAX(WINDOW_MAX)
	) u_monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.close_price   (close_price),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.simple_average(simple_average),
		.exp_average   (exp_average),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.run_done      (run_done),
		.results_seen  (results_seen),
		.error_count   (error_count)
	);

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
	end

	// Ends the run if no word moves on any channel for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic set_idle(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				sender_idle_pct = 0;
				receiver_stall_pct = 0;
			end
			IDLE_SENDER: begin
				sender_idle_pct = 88;
				receiver_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				sender_idle_pct = 0;
				receiver_stall_pct = 88;
			end
			default: begin
				sender_idle_pct = 9;
				receiver_stall_pct = 9;
			end
		endcase
	endtask

	// Valid is only dropped for a gap, so back-to-back words keep it high.
	task automatic send_price(input logic [PRICE_W-1:0] price);
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < sender_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		close_price <= price;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
		input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// The bits above the window length field carry noise, which must be dropped.
	task automatic configure(input int unsigned span, input logic [WEIGHT_W-1:0] weight);
		logic [CFG_DATA_W-1:0] data;
		data = CFG_DATA_W'($urandom);
		data[WL_W-1:0] = span[WL_W-1:0];
		write_reg(REG_WINDOW_LENGTH, data);
		write_reg(REG_EMA_WEIGHT, weight);
		cfg_valid <= 1'b0;
	endtask

	// Waits until every price has its result word and the block has gone quiet.
	task automatic settle();
		in_valid <= 1'b0;
		while (results_seen != items_sent)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	function automatic logic [WEIGHT_W-1:0] weight_for(input int unsigned span);
		int unsigned n;
		n = (span == 0) ? 1 : (span > WINDOW_MAX) ? WINDOW_MAX : span;
		return WEIGHT_W'((2 * int'(WEIGHT_ONE)) / (n + 1));
	endfunction

	// Mostly a drifting market price, with full-range and edge values mixed in.
	function automatic logic [PRICE_W-1:0] next_price();
		case ($urandom_range(0, 7))
			0: return PRICE_W'($urandom);
			1: return PRICE_W'($urandom_range(0, 255));
			2: return ~PRICE_W'($urandom_range(0, 255));
			default: begin
				price_level = price_level + PRICE_W'($urandom_range(0, 2047)) - 32'd1024;
				return price_level;
			end
		endcase
	endfunction

	initial begin
		int unsigned span;
		logic [WEIGHT_W-1:0] weight;
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_idle(IDLE_NONE);

		// Settings from reset: window of one, full weight.
		send_price(32'hFFFF_FFFF);
		send_price(32'h0000_0000);

		// Oversized window with zero weight, while fewer prices than the window exist.
		settle();
		configure(127, '0);
		send_price(32'hFFFF_FFFF);
		send_price(32'h0000_0001);
		send_price(32'h8000_0000);

		// Writes to unused indexes, a zero window and a weight above one.
		settle();
		write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
		write_reg(REG_SPARE_B, '1);
		configure(0, '1);
		send_price(32'h1234_5678);
		send_price(32'hFFFF_FFFF);

		settle();
		configure(8, weight_for(8));
		send_price(32'hAAAA_AAAA);
		send_price(32'h5555_5555);
		send_price(32'h0000_0000);
		send_price(32'hFFFF_FFFF);
		send_price(32'h0001_0000);
		send_price(32'hFFFF_0000);

		settle();
		configure(WINDOW_MAX, '0);
		send_price(32'hFFFF_FFFF);
		send_price(32'hFFFF_FFFF);
		send_price(32'h0000_0001);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph % 3 == 0) begin
				case (ph / 3)
					0: span = WINDOW_MAX;
					1: span = 0;
					2: span = 127;
					default: span = $urandom_range(WINDOW_MAX + 1, 126);
				endcase
			end else begin
				span = $urandom_range(1, 16);
			end
			case ($urandom_range(0, 5))
				0: weight = '0;
				1: weight = WEIGHT_ONE;
				2: weight = '1;
				3: weight = WEIGHT_W'($urandom_range(0, 17'h1FFFF));
				default: weight = weight_for(span);
			endcase
			settle();
			set_idle(idle_mode_t'(ph % 4));
			configure(span, weight);
			repeat (ITEMS_PER_PHASE)
				send_price(next_price());
		end

		settle();
		run_done <= 1'b1;
		repeat (2)
			@(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
